/* design/peak_window_extractor_macros.svh */
// ----------------------------------------------------------------------------
// peak window extractor assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PEAK_WINDOW_EXTRACTOR_MACROS_SVH
`define PEAK_WINDOW_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define PWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pwe_pkg.sv */
// ----------------------------------------------------------------------------
// pwe_pkg
// shared widths, defaults, register indexes and control types
// ----------------------------------------------------------------------------
package pwe_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PEAK_IDX_W  = 12;
  localparam int SLOT_W      = 4;
  localparam int DEV_W       = 17;
  localparam int DELTA_W     = 15;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int DEF_SAMPLES_BEFORE   = 5;
  localparam int DEF_SAMPLES_AFTER    = 9;
  localparam int DEF_MAX_WAVEFORM_LEN = 4096;

  localparam logic signed [SAMPLE_W-1:0] AMP_RESET   = 16'sd983;
  localparam logic        [DELTA_W-1:0]  DELTA_RESET = 15'd33;

  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA     = 2'd3;

  typedef struct packed {
    logic shift;   // push a new sample in at the tail
    logic rotate;  // move the head round to the tail
  } hist_ctrl_t;

endpackage

/* design/pwe_in_if.sv */
// ----------------------------------------------------------------------------
// pwe_in_if
// sample channel: valid/ready with one waveform sample per transfer
// ----------------------------------------------------------------------------
interface pwe_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pwe_pkg::SAMPLE_W-1:0]   sample;
  logic                                  end_of_waveform;

  modport source (output valid, output sample, output end_of_waveform, input ready);
  modport sink   (input valid, input sample, input end_of_waveform, output ready);
endinterface

/* design/pwe_out_if.sv */
// ----------------------------------------------------------------------------
// pwe_out_if
// result channel: valid/ready with one window slot per transfer
// ----------------------------------------------------------------------------
interface pwe_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [pwe_pkg::PEAK_IDX_W-1:0] peak_index;
  logic        [pwe_pkg::SLOT_W-1:0]     slot;
  logic signed [pwe_pkg::DEV_W-1:0]      deviation;
  logic signed [pwe_pkg::SAMPLE_W-1:0]   window_mean;
  logic                                  last_of_window;

  modport source (output valid, output peak_index, output slot, output deviation,
                  output window_mean, output last_of_window, input ready);
  modport sink   (input valid, input peak_index, input slot, input deviation,
                  input window_mean, input last_of_window, output ready);
endinterface

/* design/pwe_history.sv */
// ----------------------------------------------------------------------------
// pwe_history
// sample history line with shift-in and rotate, fixed taps around the peak
// ----------------------------------------------------------------------------
module pwe_history #(
  parameter int DEPTH  = 15,
  parameter int BEFORE = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pwe_pkg::hist_ctrl_t                 ctrl,
  input  logic signed [pwe_pkg::SAMPLE_W-1:0] din,
  output logic signed [pwe_pkg::SAMPLE_W-1:0] head,
  output logic signed [pwe_pkg::SAMPLE_W-1:0] left,
  output logic signed [pwe_pkg::SAMPLE_W-1:0] center,
  output logic signed [pwe_pkg::SAMPLE_W-1:0] right
);

  logic signed [pwe_pkg::SAMPLE_W-1:0] hist [DEPTH];
  logic signed [pwe_pkg::SAMPLE_W-1:0] tail_in;

  assign tail_in = ctrl.shift ? din : hist[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (ctrl.shift || ctrl.rotate) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[DEPTH-1] <= tail_in;
    end
  end

  assign head   = hist[0];
  assign left   = hist[BEFORE-1];
  assign center = hist[BEFORE];
  assign right  = hist[BEFORE+1];

endmodule

/* design/pwe_divider.sv */
// ----------------------------------------------------------------------------
// pwe_divider
// division by a fixed divisor through a registered reciprocal multiply
// ----------------------------------------------------------------------------
module pwe_divider #(
  parameter int DIVISOR = 15,
  parameter int WIDTH   = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  output logic [WIDTH-1:0] quotient,
  output logic             done
);

  // floor(n / DIVISOR) == (n * RECIP) >> SHIFT for every n below 2**WIDTH
  localparam int SHIFT   = WIDTH + $clog2(DIVISOR);
  localparam int RECIP_W = WIDTH + 1;
  localparam int PROD_W  = WIDTH + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic              busy;
  logic [WIDTH-1:0]  num;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // operand registered on start, product registered while busy
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (busy) begin
      prod <= PROD_W'(num) * PROD_W'(RECIP);
    end
  end

  assign quotient = WIDTH'(prod[PROD_W-1:SHIFT]);

endmodule

/* design/peak_window_extractor.sv */
// ----------------------------------------------------------------------------
// peak_window_extractor
// waveform bump finder that emits a mean-subtracted window around each peak
// ----------------------------------------------------------------------------
// in_ch carries one sample per transfer, end_of_waveform on the last one of
// a waveform. A bump is judged once the last sample of its window is in:
// the window is summed sample by sample through the shared accumulate
// adder, the sum is divided by the window length with a registered
// reciprocal multiply, then one result per window slot leaves on out_ch,
// last_of_window set on the final slot. A sample with no bump goes from
// CHECK back to IDLE; one that completes a bump runs on through SUM over
// the W = BEFORE + 1 + AFTER samples (15 with the default window), DSTART,
// DWAIT and EMIT, which sends one slot per cycle while the receiver does
// not stall. in_ch.ready is high only while the block waits for a sample.
// Results sit in an output register; a stalled receiver holds the current
// result and stops the slot sequence. Reset (rst, synchronous) clears the
// history to zero, the sample position, the output valid and the registers
// to their defaults. Configuration is written on cfg_we; the user must write
// it only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module peak_window_extractor #(
  parameter int SAMPLES_BEFORE   = pwe_pkg::DEF_SAMPLES_BEFORE,
  parameter int SAMPLES_AFTER    = pwe_pkg::DEF_SAMPLES_AFTER,
  parameter int MAX_WAVEFORM_LEN = pwe_pkg::DEF_MAX_WAVEFORM_LEN
) (
  input  logic                            clk,
  input  logic                            rst,
  pwe_in_if.sink                          in_ch,
  pwe_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pwe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwe_pkg::CFG_W-1:0]       cfg_data
);

  `include "peak_window_extractor_macros.svh"

  localparam int WIN_LEN = SAMPLES_BEFORE + 1 + SAMPLES_AFTER;
  localparam int SUM_W   = pwe_pkg::SAMPLE_W + $clog2(WIN_LEN);
  localparam int CNT_W   = $clog2(WIN_LEN);
  localparam int POS_W   = $clog2(MAX_WAVEFORM_LEN);
  localparam int IDX_W   = (pwe_pkg::PEAK_IDX_W > POS_W) ? pwe_pkg::PEAK_IDX_W : POS_W;
  localparam int SW      = pwe_pkg::SAMPLE_W;
  localparam int DW      = pwe_pkg::DEV_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // configuration
  logic                          invert_polarity;
  logic                          require_local_max;
  logic signed [SW-1:0]          amplitude_threshold;
  logic [pwe_pkg::DELTA_W-1:0]   delta_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_polarity     <= 1'b0;
      require_local_max   <= 1'b0;
      amplitude_threshold <= pwe_pkg::AMP_RESET;
      delta_threshold     <= pwe_pkg::DELTA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pwe_pkg::REG_INVERT:    invert_polarity     <= cfg_data[0];
        pwe_pkg::REG_LOCAL_MAX: require_local_max   <= cfg_data[0];
        pwe_pkg::REG_AMP:       amplitude_threshold <= cfg_data[SW-1:0];
        pwe_pkg::REG_DELTA:     delta_threshold     <= cfg_data[pwe_pkg::DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [2:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [POS_W-1:0]      pos;
  logic                  win_ok;
  logic [IDX_W-1:0]      peak;
  logic signed [SUM_W-1:0] acc;
  logic                  acc_neg;
  logic signed [SW-1:0]  mean;

  logic                  in_xfer;
  logic                  out_free;
  logic                  cnt_last;
  logic signed [SW-1:0]  s_in;
  logic signed [SW-1:0]  head;
  logic signed [SW-1:0]  tap_l;
  logic signed [SW-1:0]  tap_c;
  logic signed [SW-1:0]  tap_r;
  pwe_pkg::hist_ctrl_t   hctrl;

  logic                  div_start;
  logic [SUM_W-1:0]      div_quo;
  logic                  div_done;
  logic [SUM_W-1:0]      acc_mag;
  logic [SUM_W-1:0]      mean_full;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign cnt_last    = (cnt == CNT_W'(WIN_LEN - 1));

  // negation saturates the most negative code
  assign s_in = !invert_polarity ? in_ch.sample :
                (in_ch.sample == {1'b1, {(SW-1){1'b0}}}) ? {1'b0, {(SW-1){1'b1}}} :
                -in_ch.sample;

  assign hctrl = '{shift:  in_xfer,
                   rotate: (state == ST_SUM) || ((state == ST_EMIT) && out_free)};

  pwe_history #(
    .DEPTH  (WIN_LEN),
    .BEFORE (SAMPLES_BEFORE)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (hctrl),
    .din    (s_in),
    .head   (head),
    .left   (tap_l),
    .center (tap_c),
    .right  (tap_r)
  );

  // bump test on the fixed taps
  logic signed [SW+1:0] twice_c;
  logic signed [SW+1:0] l_plus_r;
  logic signed [SW:0]   c_minus_l;
  logic signed [SW:0]   c_minus_r;
  logic signed [SW:0]   delta_ext;
  logic                 bump;
  logic                 strict_ok;

  assign twice_c   = {tap_c[SW-1], tap_c, 1'b0};
  assign l_plus_r  = (SW+2)'(tap_l) + (SW+2)'(tap_r);
  assign c_minus_l = (SW+1)'(tap_c) - (SW+1)'(tap_l);
  assign c_minus_r = (SW+1)'(tap_c) - (SW+1)'(tap_r);
  assign delta_ext = {2'b00, delta_threshold};
  assign strict_ok = (tap_c >= amplitude_threshold) && (c_minus_l > delta_ext) &&
                     (c_minus_r > delta_ext);
  assign bump      = win_ok && (twice_c > l_plus_r) && (!require_local_max || strict_ok);

  // magnitude taken from the finished sum while the divider loads it
  assign acc_mag   = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
  assign div_start = (state == ST_DSTART);
  assign mean_full = acc_neg ? -div_quo : div_quo;

  pwe_divider #(
    .DIVISOR (WIN_LEN),
    .WIDTH   (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_ch.end_of_waveform || (32'(pos) + 32'd1 >= 32'(MAX_WAVEFORM_LEN))) begin
              pos <= '0;
            end else begin
              pos <= pos + 1'b1;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt   <= '0;
          state <= bump ? ST_SUM : ST_IDLE;
        end
        ST_SUM: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= ST_DSTART;
          end
        end
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            cnt   <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            cnt <= cnt + 1'b1;
            if (cnt_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_ok <= 32'(pos) >= 32'(SAMPLES_BEFORE + SAMPLES_AFTER);
      peak   <= IDX_W'(pos) - IDX_W'(SAMPLES_AFTER);
    end
    if (state == ST_CHECK) begin
      acc <= '0;
    end else if (state == ST_SUM) begin
      acc <= acc + SUM_W'(head);
    end
    if (state == ST_DSTART) begin
      acc_neg <= acc[SUM_W-1];
    end
    if ((state == ST_DWAIT) && div_done) begin
      mean <= mean_full[SW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      out_ch.peak_index     <= peak[pwe_pkg::PEAK_IDX_W-1:0];
      out_ch.slot           <= pwe_pkg::SLOT_W'(cnt);
      out_ch.deviation      <= DW'(head) - DW'(mean);
      out_ch.window_mean    <= mean;
      out_ch.last_of_window <= cnt_last;
    end
  end

  `PWE_ASSERT_NOW(a_div_done_waiting, div_done, state == ST_DWAIT,
    "divider finished outside wait")
  `PWE_ASSERT_NOW(a_last_slot, out_ch.valid && out_ch.last_of_window,
    out_ch.slot == pwe_pkg::SLOT_W'(WIN_LEN - 1), "window end on wrong slot")
  `PWE_ASSERT_NOW(a_mid_window, out_ch.valid && out_ch.ready && !out_ch.last_of_window,
    state == ST_EMIT, "window ended early")
  `PWE_ASSERT_NEXT(a_hold_stalled, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.slot), "stalled result not held")

endmodule

/* sim/peak_window_extractor_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peak_window_extractor_tb
// drives waveform samples with random idling on both channels, predicts each
// emitted window from its own copy of the sample history and position, and
// compares every result transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module peak_window_extractor_tb;

  localparam int SAMPLE_W       = pwe_pkg::SAMPLE_W;
  localparam int PEAK_IDX_W     = pwe_pkg::PEAK_IDX_W;
  localparam int SLOT_W         = pwe_pkg::SLOT_W;
  localparam int DEV_W          = pwe_pkg::DEV_W;
  localparam int DELTA_W        = pwe_pkg::DELTA_W;
  localparam int CFG_W          = pwe_pkg::CFG_W;
  localparam int CFG_IDX_W      = pwe_pkg::CFG_IDX_W;
  localparam int CLK_PERIOD     = 10;
  localparam int BEFORE         = pwe_pkg::DEF_SAMPLES_BEFORE;
  localparam int AFTER          = pwe_pkg::DEF_SAMPLES_AFTER;
  localparam int WIN            = BEFORE + 1 + AFTER;
  localparam int MAX_LEN        = pwe_pkg::DEF_MAX_WAVEFORM_LEN;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIR_ROWS       = 22;

  typedef struct packed {
    logic [PEAK_IDX_W-1:0]      peak_index;
    logic [SLOT_W-1:0]          slot;
    logic signed [DEV_W-1:0]    deviation;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic                       last_of_window;
  } window_result_t;

  // none_due marks rows that cannot complete a window
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       eow;
    logic                       none_due;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pwe_in_if  in_ch ();
  pwe_out_if out_ch ();

  peak_window_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic                       inv_pol;
  logic                       need_max;
  logic signed [SAMPLE_W-1:0] amp_thr;
  logic [DELTA_W-1:0]         margin_thr;
  logic signed [SAMPLE_W-1:0] shaped_hist [WIN];
  logic [PEAK_IDX_W-1:0]      wave_pos;

  window_result_t pending_windows [$];
  window_result_t want_res;
  int mismatch_count;
  int quiet_cycles;
  int rx_hold;
  bit idle_en;

  // input values; the directed part runs with polarity inverted
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'sh8000, 1'b0, 1'b1},  // saturates on negation
    '{16'sh7FFF, 1'b0, 1'b1},
    '{16'sh0000, 1'b0, 1'b1},
    '{-16'sd1000, 1'b0, 1'b1}, // bump too close to the start
    '{16'sh7FFF, 1'b0, 1'b1},
    '{16'sh8000, 1'b0, 1'b1},  // full scale spike
    '{16'sh7FFF, 1'b0, 1'b1},
    '{16'sh0000, 1'b0, 1'b1},
    '{16'sh0000, 1'b0, 1'b1},
    '{-16'sd16384, 1'b0, 1'b1},
    '{16'sh0000, 1'b0, 1'b1},
    '{-16'sd20000, 1'b0, 1'b1}, // bump too close to the end
    '{16'sh0000, 1'b0, 1'b1},
    '{16'sh0000, 1'b0, 1'b1},
    '{16'sh0000, 1'b0, 1'b0},
    '{16'sh0000, 1'b0, 1'b0},
    '{16'sh0000, 1'b0, 1'b0},
    '{16'sh0000, 1'b0, 1'b0},
    '{16'sh0000, 1'b1, 1'b0},
    '{16'sh3039, 1'b1, 1'b1},  // one-sample waveform
    '{16'sh5555, 1'b0, 1'b1},
    '{16'shAAAA, 1'b1, 1'b1}
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return SAMPLE_W'(v);
  endfunction

  // shift one sample in and queue the window it completes, if any
  function automatic int predict_windows(input logic signed [SAMPLE_W-1:0] raw,
                                         input logic eow);
    logic signed [SAMPLE_W-1:0] s;
    int c_val, l_val, r_val, sum, mean, k;
    bit hit;
    window_result_t res;
    s = raw;
    if (inv_pol) s = (raw == 16'sh8000) ? 16'sh7FFF : -raw;
    for (k = 0; k < WIN - 1; k++) shaped_hist[k] = shaped_hist[k+1];
    shaped_hist[WIN-1] = s;
    hit = 1'b0;
    if (int'(wave_pos) >= BEFORE + AFTER) begin
      c_val = shaped_hist[BEFORE];
      l_val = shaped_hist[BEFORE-1];
      r_val = shaped_hist[BEFORE+1];
      hit = 2 * c_val > l_val + r_val;
      if (hit && need_max)
        hit = c_val >= int'(amp_thr) && c_val - l_val > int'(margin_thr) &&
              c_val - r_val > int'(margin_thr);
    end
    if (hit) begin
      sum = 0;
      for (k = 0; k < WIN; k++) sum += shaped_hist[k];
      mean = sum / WIN;
      for (k = 0; k < WIN; k++) begin
        res.peak_index     = wave_pos - PEAK_IDX_W'(AFTER);
        res.slot           = SLOT_W'(k);
        res.deviation      = DEV_W'(int'(shaped_hist[k]) - mean);
        res.window_mean    = SAMPLE_W'(mean);
        res.last_of_window = (k == WIN - 1);
        pending_windows    = {pending_windows, res};
      end
    end
    if (eow || int'(wave_pos) + 1 >= MAX_LEN) wave_pos = '0;
    else wave_pos = wave_pos + 1'b1;
    return hit ? WIN : 0;
  endfunction

  task automatic log_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s expected %0d got %0d", mismatch_count, what, want, got);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eow,
                             output int made);
    int gap;
    gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           = 1'b1;
    in_ch.sample          = s;
    in_ch.end_of_waveform = eow;
    do @(posedge clk); while (!in_ch.ready);
    made = predict_windows(s, eow);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      pwe_pkg::REG_INVERT:    inv_pol    = data[0];
      pwe_pkg::REG_LOCAL_MAX: need_max   = data[0];
      pwe_pkg::REG_AMP:       amp_thr    = data;
      pwe_pkg::REG_DELTA:     margin_thr = data[DELTA_W-1:0];
      default: ;
    endcase
  endtask

  // modes_only leaves the thresholds as they are
  task automatic apply_setting(input logic inv, input logic lm,
                               input logic signed [SAMPLE_W-1:0] amp,
                               input logic [DELTA_W-1:0] delta, input bit modes_only);
    write_reg(pwe_pkg::REG_INVERT, CFG_W'(inv));
    write_reg(pwe_pkg::REG_LOCAL_MAX, CFG_W'(lm));
    if (!modes_only) begin
      write_reg(pwe_pkg::REG_AMP, amp);
      write_reg(pwe_pkg::REG_DELTA, CFG_W'(delta));
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // sender holds off until every window is out and the block has settled
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int target);
    int sent, len, kind, peak_at, p, made;
    logic signed [SAMPLE_W-1:0] s, bump_c, bump_l, bump_r;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      len  = (kind == 0) ? $urandom_range(1, WIN - 1) : $urandom_range(WIN, 40);
      peak_at = 0;
      if (len >= WIN)
        peak_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len - 2)
                                              : $urandom_range(BEFORE, len - 1 - AFTER);
      // peak within one of the amplitude threshold, neighbours at the margin or one beyond it
      bump_c = clamp_sample(int'(amp_thr) + int'($urandom_range(0, 2)) - 1);
      bump_l = clamp_sample(int'(bump_c) - int'(margin_thr) - int'($urandom_range(0, 1)));
      bump_r = clamp_sample(int'(bump_c) - int'(margin_thr) - int'($urandom_range(0, 1)));
      for (p = 0; p < len; p++) begin
        s = clamp_sample(int'($urandom_range(0, 400)) - 200);
        if (kind <= 2) begin
          s = 16'($urandom);
        end else if (kind <= 6) begin
          if (p == peak_at || (kind == 6 && p == peak_at + 1)) s = 16'($urandom);
        end else begin
          if (p == peak_at) s = bump_c;
          else if (p == peak_at - 1) s = bump_l;
          else if (p == peak_at + 1) s = bump_r;
          if (inv_pol) s = clamp_sample(-int'(s));
        end
        send_sample(s, p == len - 1, made);
      end
      sent += len;
    end
  endtask

  // result receiver with stall bursts
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ch.ready = 1'b0;
      rx_hold--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      rx_hold = $urandom_range(0, 17);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_windows.size() == 0) begin
        log_mismatch("unexpected result, peak_index", -1, int'(out_ch.peak_index));
      end else begin
        want_res = pending_windows.pop_front();
        if (out_ch.peak_index !== want_res.peak_index)
          log_mismatch("peak_index", want_res.peak_index, out_ch.peak_index);
        if (out_ch.slot !== want_res.slot)
          log_mismatch("slot", want_res.slot, out_ch.slot);
        if (out_ch.deviation !== want_res.deviation)
          log_mismatch("deviation", want_res.deviation, out_ch.deviation);
        if (out_ch.window_mean !== want_res.window_mean)
          log_mismatch("window_mean", want_res.window_mean, out_ch.window_mean);
        if (out_ch.last_of_window !== want_res.last_of_window)
          log_mismatch("last_of_window", want_res.last_of_window, out_ch.last_of_window);
      end
    end
  end

  // counts cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i, made;
    clk                   = 1'b0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.sample          = '0;
    in_ch.end_of_waveform = 1'b0;
    out_ch.ready          = 1'b1;
    rx_hold               = 0;
    quiet_cycles          = 0;
    mismatch_count        = 0;
    idle_en               = 1'b1;
    inv_pol               = 1'b0;
    need_max              = 1'b0;
    amp_thr               = pwe_pkg::AMP_RESET;
    margin_thr            = pwe_pkg::DELTA_RESET;
    wave_pos              = '0;
    for (i = 0; i < WIN; i++) shaped_hist[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apply_setting(1'b1, 1'b0, '0, '0, 1'b1);
    for (i = 0; i < DIR_ROWS; i++) begin
      send_sample(dir_rows[i].sample, dir_rows[i].eow, made);
      if (dir_rows[i].none_due && made != 0)
        log_mismatch("window count of directed row", 0, made);
    end
    drain_results();

    // thresholds still at their reset values
    apply_setting(1'b0, 1'b1, '0, '0, 1'b1);
    run_random(20);
    drain_results();

    apply_setting(1'b1, 1'b1, 16'sh8000, 15'd0, 1'b0);
    run_random(20);
    drain_results();

    idle_en = 1'b0;
    apply_setting(1'b0, 1'b1, 16'sh7FFF, 15'h7FFF, 1'b0);
    run_random(20);
    drain_results();

    idle_en = 1'b1;
    apply_setting(1'b1, 1'b0, 16'($urandom), 15'($urandom), 1'b0);
    run_random(20);
    drain_results();

    apply_setting(1'b0, 1'b0, 16'sh0000, 15'd16384, 1'b0);
    run_random(20);
    drain_results();

    idle_en = 1'b0;
    apply_setting(1'($urandom), 1'b1, SAMPLE_W'($urandom_range(0, 3000)),
                  DELTA_W'($urandom_range(0, 200)), 1'b0);
    run_random(25);
    drain_results();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
